### rtl/core/dnl_pkg.sv
// ----------------------------------------------------------------------------
// dnl_pkg
// shared constants, codes and controller/datapath types of the directory
// name lookup
// ----------------------------------------------------------------------------
package dnl_pkg;

    // default sizes of the directory table
    localparam int ENTRIES_DEF    = 64;
    localparam int NAME_BYTES_DEF = 32;

    // fixed port field widths
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 6;
    localparam int POS_W  = 5;
    localparam int BYTE_W = 8;
    localparam int WORD_W = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_NAME   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENTRY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    localparam logic [BYTE_W-1:0] NUL_CHAR = 8'h00;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHAR,
        S_TERM,
        S_SCAN,
        S_READ
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic name_wr;
        logic ent_wr;
        logic row_rd;
        logic cmp_char;
        logic build_mask;
        logic scan_step;
        logic tbl_rd;
        logic out_hit;
        logic out_miss;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic mask_empty;
        logic mask_lsb;
    } t_dp_status;

endpackage

### rtl/core/dnl_ctrl.sv
// ----------------------------------------------------------------------------
// dnl_ctrl
// sequencer of the directory name lookup: clearing pass, item decode,
// character compare, terminator scan and result
// ----------------------------------------------------------------------------
module dnl_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [dnl_pkg::CMD_W-1:0]   i_cmd,
    input  logic                        i_last,
    input  dnl_pkg::t_dp_status         i_status,
    output dnl_pkg::t_dp_cmd            o_dp_cmd,
    output logic                        busy
);

    dnl_pkg::t_state r_state;
    dnl_pkg::t_state n_state;
    logic            accept;

    assign accept = start && (r_state == dnl_pkg::S_IDLE);
    assign busy   = (r_state != dnl_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dnl_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dnl_pkg::S_CLEAR: begin
                if (i_status.clr_done) n_state = dnl_pkg::S_IDLE;
            end
            dnl_pkg::S_IDLE: begin
                if (accept && (i_cmd == dnl_pkg::CMD_LOOKUP)) begin
                    n_state = i_last ? dnl_pkg::S_TERM : dnl_pkg::S_CHAR;
                end
            end
            dnl_pkg::S_CHAR: n_state = dnl_pkg::S_IDLE;
            dnl_pkg::S_TERM: n_state = dnl_pkg::S_SCAN;
            dnl_pkg::S_SCAN: begin
                if (i_status.mask_empty)    n_state = dnl_pkg::S_IDLE;
                else if (i_status.mask_lsb) n_state = dnl_pkg::S_READ;
            end
            dnl_pkg::S_READ: n_state = dnl_pkg::S_IDLE;
            default:         n_state = dnl_pkg::S_CLEAR;
        endcase
    end

    // datapath commands
    always_comb begin
        o_dp_cmd = '0;
        case (r_state)
            dnl_pkg::S_CLEAR: o_dp_cmd.clr_step = 1'b1;
            dnl_pkg::S_IDLE: begin
                o_dp_cmd.name_wr = accept && (i_cmd == dnl_pkg::CMD_NAME);
                o_dp_cmd.ent_wr  = accept && (i_cmd == dnl_pkg::CMD_ENTRY);
                o_dp_cmd.row_rd  = accept && (i_cmd == dnl_pkg::CMD_LOOKUP);
            end
            dnl_pkg::S_CHAR: o_dp_cmd.cmp_char   = 1'b1;
            dnl_pkg::S_TERM: o_dp_cmd.build_mask = 1'b1;
            dnl_pkg::S_SCAN: begin
                o_dp_cmd.out_miss  = i_status.mask_empty;
                o_dp_cmd.tbl_rd    = !i_status.mask_empty && i_status.mask_lsb;
                o_dp_cmd.scan_step = !i_status.mask_empty && !i_status.mask_lsb;
            end
            dnl_pkg::S_READ: o_dp_cmd.out_hit = 1'b1;
            default:         o_dp_cmd = '0;
        endcase
    end

endmodule

### rtl/core/dnl_datapath.sv
// ----------------------------------------------------------------------------
// dnl_datapath
// name, type and inode memories, per-entry match bits, terminator scan and
// result registers
// ----------------------------------------------------------------------------
module dnl_datapath #(
    parameter int ENTRIES    = dnl_pkg::ENTRIES_DEF,
    parameter int NAME_BYTES = dnl_pkg::NAME_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dnl_pkg::t_dp_cmd            i_dp_cmd,
    input  logic [dnl_pkg::IDX_W-1:0]   i_entry_index,
    input  logic [dnl_pkg::POS_W-1:0]   i_char_pos,
    input  logic [dnl_pkg::BYTE_W-1:0]  i_byte_value,
    input  logic [dnl_pkg::WORD_W-1:0]  i_file_type,
    input  logic [dnl_pkg::WORD_W-1:0]  i_inode_number,
    output dnl_pkg::t_dp_status         o_status,
    output logic                        o_valid,
    output logic                        o_found,
    output logic [dnl_pkg::IDX_W-1:0]   o_match_index,
    output logic [dnl_pkg::WORD_W-1:0]  o_match_type,
    output logic [dnl_pkg::WORD_W-1:0]  o_match_inode
);

    localparam int BW      = dnl_pkg::BYTE_W;
    localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW      = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
    localparam int CW      = $clog2(NAME_BYTES + 1);
    localparam int CLR_LEN = (ENTRIES > NAME_BYTES) ? ENTRIES : NAME_BYTES;
    localparam int CLW     = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;

    // one row per character position, one byte lane per entry
    logic [ENTRIES*BW-1:0]          r_name_mem [NAME_BYTES];
    logic [dnl_pkg::WORD_W-1:0]     r_type_mem [ENTRIES];
    logic [dnl_pkg::WORD_W-1:0]     r_inode_mem [ENTRIES];

    logic [ENTRIES*BW-1:0]          r_row_q;
    logic [BW-1:0]                  r_char;
    logic [dnl_pkg::WORD_W-1:0]     r_type_q;
    logic [dnl_pkg::WORD_W-1:0]     r_inode_q;

    logic [ENTRIES-1:0]             r_still_equal;
    logic [ENTRIES-1:0]             n_still_equal;
    logic [CW-1:0]                  r_chars_seen;
    logic                           r_too_long;
    logic [ENTRIES-1:0]             r_mask;
    logic [ENTRIES-1:0]             n_mask;
    logic [IW-1:0]                  r_scan_idx;
    logic [CLW-1:0]                 r_clr_cnt;

    logic                           r_out_valid;
    logic                           r_found;
    logic [dnl_pkg::IDX_W-1:0]      r_match_index;
    logic [dnl_pkg::WORD_W-1:0]     r_match_type;
    logic [dnl_pkg::WORD_W-1:0]     r_match_inode;

    logic                           name_ok;
    logic                           ent_ok;
    logic                           seen_full;
    logic                           clr_name_ok;
    logic                           clr_ent_ok;
    logic [IW-1:0]                  wr_ent;
    logic [RW-1:0]                  wr_row;
    logic [RW-1:0]                  rd_row;

    assign ent_ok      = (int'(i_entry_index) < ENTRIES);
    assign name_ok     = ent_ok && (int'(i_char_pos) < NAME_BYTES);
    assign wr_ent      = IW'(i_entry_index);
    assign wr_row      = RW'(i_char_pos);
    assign seen_full   = (int'(r_chars_seen) >= NAME_BYTES);
    assign rd_row      = seen_full ? '0 : r_chars_seen[RW-1:0];
    assign clr_name_ok = (int'(r_clr_cnt) < NAME_BYTES);
    assign clr_ent_ok  = (int'(r_clr_cnt) < ENTRIES);

    // name memory: byte lane writes, one row read per lookup item
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.clr_step && clr_name_ok) begin
            r_name_mem[RW'(r_clr_cnt)] <= '0;
        end else if (i_dp_cmd.name_wr && name_ok) begin
            r_name_mem[wr_row][wr_ent*BW +: BW] <= i_byte_value;
        end
        if (i_dp_cmd.row_rd) begin
            r_row_q <= r_name_mem[rd_row];
            r_char  <= i_byte_value;
        end
    end

    // type and inode memories
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.clr_step && clr_ent_ok) begin
            r_type_mem[IW'(r_clr_cnt)]  <= '0;
            r_inode_mem[IW'(r_clr_cnt)] <= '0;
        end else if (i_dp_cmd.ent_wr && ent_ok) begin
            r_type_mem[wr_ent]  <= i_file_type;
            r_inode_mem[wr_ent] <= i_inode_number;
        end
        if (i_dp_cmd.tbl_rd) begin
            r_type_q  <= r_type_mem[r_scan_idx];
            r_inode_q <= r_inode_mem[r_scan_idx];
        end
    end

    // per-entry compare of the current character, and terminator candidates
    always_comb begin
        for (int e = 0; e < ENTRIES; e++) begin
            n_still_equal[e] = r_still_equal[e] && (r_char != dnl_pkg::NUL_CHAR) &&
                               (r_row_q[e*BW +: BW] == r_char);
            n_mask[e]        = r_still_equal[e] &&
                               (seen_full || (r_row_q[e*BW +: BW] == dnl_pkg::NUL_CHAR));
        end
    end

    // lookup state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_still_equal <= '1;
            r_chars_seen  <= '0;
            r_too_long    <= 1'b0;
            r_clr_cnt     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= i_dp_cmd.out_hit || i_dp_cmd.out_miss;
            if (i_dp_cmd.clr_step) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (i_dp_cmd.cmp_char) begin
                if (seen_full) begin
                    r_too_long <= 1'b1;
                end else begin
                    r_still_equal <= n_still_equal;
                    r_chars_seen  <= r_chars_seen + 1'b1;
                end
            end else if (i_dp_cmd.build_mask) begin
                r_still_equal <= '1;
                r_chars_seen  <= '0;
                r_too_long    <= 1'b0;
            end
        end
    end

    // terminator scan, one entry a cycle from the lowest
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.build_mask) begin
            r_mask     <= (!r_too_long && (r_chars_seen != '0)) ? n_mask : '0;
            r_scan_idx <= '0;
        end else if (i_dp_cmd.scan_step) begin
            r_mask     <= r_mask >> 1;
            r_scan_idx <= r_scan_idx + 1'b1;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.out_hit) begin
            r_found       <= 1'b1;
            r_match_index <= dnl_pkg::IDX_W'(r_scan_idx);
            r_match_type  <= r_type_q;
            r_match_inode <= r_inode_q;
        end else if (i_dp_cmd.out_miss) begin
            r_found       <= 1'b0;
            r_match_index <= '0;
            r_match_type  <= '0;
            r_match_inode <= '0;
        end
    end

    assign o_status.clr_done   = (r_clr_cnt == CLW'(CLR_LEN - 1));
    assign o_status.mask_empty = (r_mask == '0);
    assign o_status.mask_lsb   = r_mask[0];

    assign o_valid       = r_out_valid;
    assign o_found       = r_found;
    assign o_match_index = r_match_index;
    assign o_match_type  = r_match_type;
    assign o_match_inode = r_match_inode;

    // character counter saturates at the name length
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_chars_seen) <= NAME_BYTES)
        else $error("chars_seen beyond name length");

    // overflow only once the counter is saturated
    a_too_long_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_too_long |-> seen_full)
        else $error("too_long set before name length reached");

    // a miss carries all-zero payload
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |->
            (r_match_index == '0 && r_match_type == '0 && r_match_inode == '0))
        else $error("not-found result with nonzero payload");

    // the scan only steps past a non-candidate while a candidate remains
    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.scan_step |=> (r_mask != '0))
        else $error("scan stepped with no candidate left");

endmodule

### rtl/core/directory_name_lookup.sv
// ----------------------------------------------------------------------------
// directory_name_lookup
// directory table of variable-length names with file type and inode per entry;
// a name arrives one character per item and the lowest matching entry is
// returned on the terminating item
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  --------------------------
//  command   in         start high, busy low         i_cmd i_entry_index
//                                                    i_char_pos i_byte_value
//                                                    i_file_type i_inode_number
//                                                    i_last
//  result    out        o_valid, one cycle, no stall o_found o_match_index
//                                                    o_match_type o_match_inode
//
//  - write items (name byte, type and inode) are taken in idle; busy stays low
//  - a lookup character is a name memory row read in idle, then a compare of
//    that row against every entry in parallel
//  - the terminating item reads its row, builds the candidate mask, scans
//    one entry a cycle for the lowest candidate and, on a hit, reads the
//    type/inode memories; the result strobe follows in the next cycle
//  - after reset a clearing pass over max(ENTRIES, NAME_BYTES) rows zeroes
//    the memories, one row a cycle, with busy high
//  - the receiver cannot stall; results are held until the next result
//
module directory_name_lookup #(
    parameter int ENTRIES    = dnl_pkg::ENTRIES_DEF,
    parameter int NAME_BYTES = dnl_pkg::NAME_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [dnl_pkg::CMD_W-1:0]   i_cmd,
    input  logic [dnl_pkg::IDX_W-1:0]   i_entry_index,
    input  logic [dnl_pkg::POS_W-1:0]   i_char_pos,
    input  logic [dnl_pkg::BYTE_W-1:0]  i_byte_value,
    input  logic [dnl_pkg::WORD_W-1:0]  i_file_type,
    input  logic [dnl_pkg::WORD_W-1:0]  i_inode_number,
    input  logic                        i_last,
    output logic                        o_valid,
    output logic                        o_found,
    output logic [dnl_pkg::IDX_W-1:0]   o_match_index,
    output logic [dnl_pkg::WORD_W-1:0]  o_match_type,
    output logic [dnl_pkg::WORD_W-1:0]  o_match_inode
);

    // commands from the sequencer, status back from the datapath
    dnl_pkg::t_dp_cmd    dp_cmd;
    dnl_pkg::t_dp_status dp_status;

    // sequencer: decodes accepted items, steps the lookup
    dnl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .i_last   (i_last),
        .i_status (dp_status),
        .o_dp_cmd (dp_cmd),
        .busy     (busy)
    );

    // memories, match bits, scan and result registers
    dnl_datapath #(
        .ENTRIES    (ENTRIES),
        .NAME_BYTES (NAME_BYTES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dp_cmd       (dp_cmd),
        .i_entry_index  (i_entry_index),
        .i_char_pos     (i_char_pos),
        .i_byte_value   (i_byte_value),
        .i_file_type    (i_file_type),
        .i_inode_number (i_inode_number),
        .o_status       (dp_status),
        .o_valid        (o_valid),
        .o_found        (o_found),
        .o_match_index  (o_match_index),
        .o_match_type   (o_match_type),
        .o_match_inode  (o_match_inode)
    );

endmodule
